// ===== rtl/ycc2rgb_pkg.sv =====
package ycc2rgb_pkg;

    // signed width that holds every weighted sum with margin
    localparam int SUM_W = 28;

    typedef logic signed [SUM_W-1:0] t_sum;
    typedef logic signed [8:0]       t_offs;

    localparam t_sum COEF_Y  = 28'sd76284;
    localparam t_sum COEF_RV = 28'sd104595;
    localparam t_sum COEF_GU = 28'sd25625;
    localparam t_sum COEF_GV = 28'sd53281;
    localparam t_sum COEF_BU = 28'sd132252;

    localparam t_offs LUMA_OFFS   = 9'sd16;
    localparam t_offs CHROMA_OFFS = 9'sd128;

    localparam logic [7:0] ALPHA_ON = 8'd255;

    // configuration register indexes
    localparam logic [1:0] REG_CHROMA_MODE  = 2'd0;
    localparam logic [1:0] REG_BLUE_FIRST   = 2'd1;
    localparam logic [1:0] REG_ALPHA_ENABLE = 2'd2;

    // arithmetic shift by 16, then limit to 0..255
    function automatic logic [7:0] scale_clamp(input t_sum s);
        logic [7:0] q;
        if (s[SUM_W-1]) begin
            q = 8'd0;
        end else if (s[SUM_W-2:24] != '0) begin
            q = 8'd255;
        end else begin
            q = s[23:16];
        end
        return q;
    endfunction

endpackage

// ===== rtl/ycbcr_to_rgb_converter_top.sv =====
// BT.601 YCbCr to RGB converter. Each input beat is one macro pixel (Cb, Cr and
// four luma slots); it yields two pixel beats in 4:2:2 mode and four in 4:1:1
// mode, in luma order. The rate is set by the single pixel output register,
// which issues one pixel per cycle while the consumer keeps m_axis_tready high;
// the next macro pixel is taken in the same cycle as the last pixel of the
// current one is issued, so the stream runs without gaps. An input beat is
// held in the macro pixel register, and its pixels pass through the pixel
// output register. Configuration writes are accepted at any time and must
// only be made while no macro pixel is in flight.
module ycbcr_to_rgb_converter_top
    import ycc2rgb_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data,

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // chroma_blue, chroma_red, luma_0, luma_1, luma_2, luma_3
    input  logic [47:0] s_axis_tdata,
    input  logic        s_axis_tlast,   // end_of_frame

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // channel_first, channel_green, channel_last, alpha_byte
    output logic [31:0] m_axis_tdata,
    // last_of_group
    output logic        m_axis_tuser,
    output logic        m_axis_tlast    // frame_done
);

    logic r_chroma_mode;
    logic r_blue_first;
    logic r_alpha_enable;

    // macro pixel register
    logic       r_in_valid;
    logic       r_in_mode;
    logic       r_in_eof;
    logic [7:0] r_luma [4];
    t_sum       r_red_c;
    t_sum       r_green_c;
    t_sum       r_blue_c;
    logic [1:0] r_pix_idx;

    // pixel output register
    logic        r_out_valid;
    logic [31:0] r_out_data;
    logic        r_out_group_last;
    logic        r_out_frame_done;

    logic       w_in_accept;
    logic       w_issue;
    logic       w_last_pix;
    t_offs      w_u;
    t_offs      w_v;
    t_offs      w_y;
    t_sum       w_ys;
    logic [7:0] w_red;
    logic [7:0] w_green;
    logic [7:0] w_blue;
    logic [7:0] w_luma_sel;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chroma_mode  <= 1'b0;
            r_blue_first   <= 1'b0;
            r_alpha_enable <= 1'b0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_CHROMA_MODE:  r_chroma_mode  <= i_cfg_data[0];
                REG_BLUE_FIRST:   r_blue_first   <= i_cfg_data[0];
                REG_ALPHA_ENABLE: r_alpha_enable <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    assign w_issue       = r_in_valid && (!r_out_valid || m_axis_tready);
    assign w_last_pix    = (r_pix_idx == (r_in_mode ? 2'd3 : 2'd1));
    assign s_axis_tready = !r_in_valid || (w_issue && w_last_pix);
    assign w_in_accept   = s_axis_tvalid && s_axis_tready;

    // chroma terms are shared by all pixels of the macro pixel
    assign w_u = t_offs'({1'b0, s_axis_tdata[7:0]}) - CHROMA_OFFS;
    assign w_v = t_offs'({1'b0, s_axis_tdata[15:8]}) - CHROMA_OFFS;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_pix_idx  <= 2'd0;
        end else if (w_in_accept) begin
            r_in_valid <= 1'b1;
            r_pix_idx  <= 2'd0;
        end else if (w_issue) begin
            if (w_last_pix) begin
                r_in_valid <= 1'b0;
            end
            r_pix_idx <= r_pix_idx + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_accept) begin
            r_in_mode <= r_chroma_mode;
            r_in_eof  <= s_axis_tlast;
            r_luma[0] <= s_axis_tdata[23:16];
            r_luma[1] <= s_axis_tdata[31:24];
            r_luma[2] <= s_axis_tdata[39:32];
            r_luma[3] <= s_axis_tdata[47:40];
            r_red_c   <= t_sum'(w_v) * COEF_RV;
            r_green_c <= -(t_sum'(w_u) * COEF_GU) - (t_sum'(w_v) * COEF_GV);
            r_blue_c  <= t_sum'(w_u) * COEF_BU;
        end
    end

    always_comb begin
        case (r_pix_idx)
            2'd0:    w_luma_sel = r_luma[0];
            2'd1:    w_luma_sel = r_luma[1];
            2'd2:    w_luma_sel = r_luma[2];
            default: w_luma_sel = r_luma[3];
        endcase
    end

    assign w_y     = t_offs'({1'b0, w_luma_sel}) - LUMA_OFFS;
    assign w_ys    = t_sum'(w_y) * COEF_Y;
    assign w_red   = scale_clamp(w_ys + r_red_c);
    assign w_green = scale_clamp(w_ys + r_green_c);
    assign w_blue  = scale_clamp(w_ys + r_blue_c);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_issue) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_issue) begin
            r_out_data[7:0]   <= r_blue_first ? w_blue : w_red;
            r_out_data[15:8]  <= w_green;
            r_out_data[23:16] <= r_blue_first ? w_red : w_blue;
            r_out_data[31:24] <= r_alpha_enable ? ALPHA_ON : 8'd0;
            r_out_group_last  <= w_last_pix;
            r_out_frame_done  <= w_last_pix && r_in_eof;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_group_last;
    assign m_axis_tlast  = r_out_frame_done;

    // a busy macro pixel that is not finishing blocks the input
    a_in_blocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !(w_issue && w_last_pix)) |-> !s_axis_tready)
        else $error("input accepted while macro pixel still in flight");

    // in 4:2:2 mode only pixel slots 0 and 1 are issued
    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !r_in_mode) |-> (r_pix_idx[1] == 1'b0))
        else $error("pixel index beyond group in 4:2:2 mode");

    // frame end only on the last pixel of a group
    a_frame_on_group_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tlast) |-> m_axis_tuser)
        else $error("frame_done without last_of_group");

    // a new pixel never overwrites one that is still waiting
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |-> !w_issue)
        else $error("output register overwritten while stalled");

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps

module tb;
    import ycc2rgb_pkg::*;

    localparam int RANDOM_ITEMS   = 340;
    localparam int SETTLE_CYCLES  = 8;
    localparam int WATCHDOG_LIMIT = 3000;

    // index with no register behind it
    localparam logic [1:0] REG_UNUSED = 2'd3;

    localparam int Y_GAIN  = 76284;
    localparam int RV_GAIN = 104595;
    localparam int GU_GAIN = 25625;
    localparam int GV_GAIN = 53281;
    localparam int BU_GAIN = 132252;

    typedef struct {
        logic [7:0] cb;
        logic [7:0] cr;
        logic [7:0] luma [4];
        logic       eof;
    } t_macro;

    typedef struct {
        logic [7:0] first_ch;
        logic [7:0] green_ch;
        logic [7:0] last_ch;
        logic [7:0] alpha;
        logic       group_end;
        logic       frame_end;
    } t_pixel;

    typedef enum logic [1:0] {
        RX_OPEN,
        RX_RANDOM,
        RX_SPARSE,
        RX_BURSTY
    } t_rx_mode;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index;
    logic [7:0]  i_cfg_data;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata;
    logic        s_axis_tlast;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;
    logic        m_axis_tuser;
    logic        m_axis_tlast;

    // register mirror
    logic mode_411;
    logic order_bgr;
    logic alpha_on;

    t_pixel   pixels_due [$];
    int       error_count = 0;
    int       burst_left  = 0;
    int       idle_cycles = 0;
    logic [7:0] stall_cycle = '0;
    t_rx_mode stall_mode  = RX_OPEN;

    ycbcr_to_rgb_converter_top u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #10 i_clk = ~i_clk;

    function automatic logic [7:0] shift_and_clamp(input int sum);
        int q;
        q = sum >>> 16;
        if (q < 0) begin
            return 8'd0;
        end
        if (q > 255) begin
            return 8'd255;
        end
        return q[7:0];
    endfunction

    // expected pixels of one macro pixel under the current register values
    task automatic expand_macro_pixel(input t_macro m);
        int     u;
        int     v;
        int     ys;
        int     count;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        t_pixel p;
        u = int'(m.cb) - 128;
        v = int'(m.cr) - 128;
        count = mode_411 ? 4 : 2;
        for (int k = 0; k < count; k++) begin
            ys    = Y_GAIN * (int'(m.luma[k]) - 16);
            red   = shift_and_clamp(ys + RV_GAIN * v);
            green = shift_and_clamp(ys - GU_GAIN * u - GV_GAIN * v);
            blue  = shift_and_clamp(ys + BU_GAIN * u);
            p.first_ch  = order_bgr ? blue : red;
            p.green_ch  = green;
            p.last_ch   = order_bgr ? red : blue;
            p.alpha     = alpha_on ? 8'd255 : 8'd0;
            p.group_end = (k == count - 1);
            p.frame_end = (k == count - 1) && m.eof;
            pixels_due.push_back(p);
        end
    endtask

    function automatic t_macro make_macro(input logic [7:0] cb, input logic [7:0] cr,
                                          input logic [7:0] y0, input logic [7:0] y1,
                                          input logic [7:0] y2, input logic [7:0] y3,
                                          input logic eof);
        t_macro m;
        m.cb      = cb;
        m.cr      = cr;
        m.luma[0] = y0;
        m.luma[1] = y1;
        m.luma[2] = y2;
        m.luma[3] = y3;
        m.eof     = eof;
        return m;
    endfunction

    function automatic logic [7:0] random_byte();
        logic [7:0] corners [6] = '{8'd0, 8'd16, 8'd128, 8'd235, 8'd240, 8'd255};
        if ($urandom_range(0, 7) == 0) begin
            return corners[$urandom_range(0, 5)];
        end
        return 8'($urandom());
    endfunction

    // one beat on the slave side; bursts with random gaps between them
    task automatic send_macro_pixel(input t_macro m);
        if (burst_left == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 60)
                                                     : $urandom_range(1, 8);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {m.luma[3], m.luma[2], m.luma[1], m.luma[0], m.cr, m.cb};
        s_axis_tlast  <= m.eof;
        do @(posedge i_clk); while (s_axis_tready !== 1'b1);
        expand_macro_pixel(m);
        burst_left--;
    endtask

    // stop the stream and wait until every pixel has come out
    task automatic drain_pipeline();
        s_axis_tvalid <= 1'b0;
        while (pixels_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] index, input logic [7:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        case (index)
            REG_CHROMA_MODE:  mode_411  = data[0];
            REG_BLUE_FIRST:   order_bgr = data[0];
            REG_ALPHA_ENABLE: alpha_on  = data[0];
            default: ;
        endcase
    endtask

    task automatic apply_config(input logic mode, input logic bgr, input logic alpha);
        drain_pipeline();
        write_reg(REG_CHROMA_MODE, {7'($urandom()), mode});
        write_reg(REG_BLUE_FIRST, {7'($urandom()), bgr});
        write_reg(REG_ALPHA_ENABLE, {7'($urandom()), alpha});
        i_cfg_valid <= 1'b0;
    endtask

    task automatic compare_field(input string name, input int expected, input int actual);
        if (expected != actual) begin
            $error("%s: expected %0d, got %0d", name, expected, actual);
            error_count++;
        end
    endtask

    // pixel checker
    always @(posedge i_clk) begin
        t_pixel p;
        if (i_rst_n === 1'b1 && m_axis_tvalid === 1'b1 && m_axis_tready) begin
            if (pixels_due.size() == 0) begin
                $error("pixel beat with nothing expected: tdata %h", m_axis_tdata);
                error_count++;
            end else begin
                p = pixels_due.pop_front();
                compare_field("channel_first", p.first_ch, m_axis_tdata[7:0]);
                compare_field("channel_green", p.green_ch, m_axis_tdata[15:8]);
                compare_field("channel_last", p.last_ch, m_axis_tdata[23:16]);
                compare_field("alpha_byte", p.alpha, m_axis_tdata[31:24]);
                compare_field("last_of_group", p.group_end, m_axis_tuser);
                compare_field("frame_done", p.frame_end, m_axis_tlast);
            end
        end
    end

    // receiver stalls, pattern changes whenever the low six bits of stall_cycle are zero
    always @(posedge i_clk) begin
        stall_cycle <= stall_cycle + 8'd1;
        if (stall_cycle[5:0] == 6'd0) begin
            stall_mode <= t_rx_mode'($urandom_range(0, 3));
        end
        case (stall_mode)
            RX_OPEN:   m_axis_tready <= 1'b1;
            RX_RANDOM: m_axis_tready <= 1'($urandom_range(0, 1));
            RX_SPARSE: m_axis_tready <= (stall_cycle[1:0] == 2'd0);
            default:   m_axis_tready <= (stall_cycle[4:3] == 2'd3);
        endcase
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready === 1'b1)
            || (m_axis_tvalid === 1'b1 && m_axis_tready)
            || (i_cfg_valid && o_cfg_ready === 1'b1)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // reset values: 4:2:2, red first, alpha off; upper lumas must be ignored
    task automatic test_reset_config();
        send_macro_pixel(make_macro(8'd128, 8'd128, 8'd16, 8'd235, 8'd77, 8'd200, 1'b0));
        send_macro_pixel(make_macro(8'd0, 8'd0, 8'd0, 8'd255, 8'd255, 8'd0, 1'b0));
        send_macro_pixel(make_macro(8'd255, 8'd255, 8'd255, 8'd0, 8'd0, 8'd255, 1'b0));
        send_macro_pixel(make_macro(8'd0, 8'd255, 8'd128, 8'd240, 8'hAA, 8'h55, 1'b0));
        send_macro_pixel(make_macro(8'd255, 8'd0, 8'd128, 8'd16, 8'h55, 8'hAA, 1'b1));
        send_macro_pixel(make_macro(8'd128, 8'd128, 8'd255, 8'd0, 8'd1, 8'd2, 1'b1));
    endtask

    // only bit 0 of the data is kept, index 3 writes nothing
    task automatic test_register_writes();
        drain_pipeline();
        write_reg(REG_UNUSED, 8'hFF);
        write_reg(REG_CHROMA_MODE, 8'hFE);
        write_reg(REG_BLUE_FIRST, 8'h01);
        write_reg(REG_ALPHA_ENABLE, 8'hFF);
        i_cfg_valid <= 1'b0;
        send_macro_pixel(make_macro(8'd0, 8'd255, 8'd235, 8'd16, 8'd9, 8'd9, 1'b0));
        send_macro_pixel(make_macro(8'd255, 8'd0, 8'd0, 8'd255, 8'd9, 8'd9, 1'b1));
        drain_pipeline();
        write_reg(REG_CHROMA_MODE, 8'h01);
        write_reg(REG_UNUSED, 8'h00);
        write_reg(REG_ALPHA_ENABLE, 8'h00);
        i_cfg_valid <= 1'b0;
        send_macro_pixel(make_macro(8'd128, 8'd128, 8'd0, 8'd16, 8'd235, 8'd255, 1'b0));
        send_macro_pixel(make_macro(8'd0, 8'd0, 8'd255, 8'd255, 8'd0, 8'd0, 1'b1));
    endtask

    // every combination of the three registers
    task automatic test_all_settings();
        for (int c = 0; c < 8; c++) begin
            apply_config(c[0], c[1], c[2]);
            send_macro_pixel(make_macro(8'($urandom()), 8'($urandom()), 8'($urandom()),
                                        8'($urandom()), 8'($urandom()), 8'($urandom()),
                                        c[0] ^ c[2]));
        end
    endtask

    task automatic test_random_stream();
        int     sent;
        int     phase_len;
        t_macro m;
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            apply_config(1'($urandom()), 1'($urandom()), 1'($urandom()));
            if ($urandom_range(0, 3) == 0) begin
                write_reg(REG_UNUSED, 8'($urandom()));
                i_cfg_valid <= 1'b0;
            end
            phase_len = $urandom_range(10, 60);
            for (int i = 0; i < phase_len && sent < RANDOM_ITEMS; i++) begin
                m = make_macro(random_byte(), random_byte(), random_byte(), random_byte(),
                               random_byte(), random_byte(), $urandom_range(0, 7) == 0);
                send_macro_pixel(m);
                sent++;
                // one full pause mid-stream
                if (sent == RANDOM_ITEMS / 2) begin
                    drain_pipeline();
                end
            end
        end
    endtask

    initial begin
        i_rst_n       <= 1'b0;
        i_cfg_valid   <= 1'b0;
        i_cfg_index   <= '0;
        i_cfg_data    <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tlast  <= 1'b0;
        mode_411  = 1'b0;
        order_bgr = 1'b0;
        alpha_on  = 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_config();
        test_register_writes();
        test_all_settings();
        test_random_stream();
        drain_pipeline();

        if (error_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
